FILE: rtl/k_way_sorted_merge_top_defines.svh
// Assertion macros shared by the merge RTL.
`ifndef K_WAY_SORTED_MERGE_TOP_DEFINES_SVH
`define K_WAY_SORTED_MERGE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define KWM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define KWM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/kwm_pkg.sv
// Types, constants and codes shared by the k-way merge RTL.
package kwm_pkg;

  // Default sizes.
  localparam int NUM_LISTS_DEF   = 8;
  localparam int VALUE_WIDTH_DEF = 16;

  // Configuration register width and reset value.
  localparam int              CFG_W        = 4;
  localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd8;

  // Result kind codes.
  localparam logic KIND_VALUE = 1'b0;
  localparam logic KIND_END   = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DECIDE
  } state_t;

  // Commands from the sequencer to every cell.
  typedef struct packed {
    logic load;       // an input transaction is being written
    logic has_value;  // the item carries a value
    logic list_end;   // the item closes its list
    logic pop;        // the selected head is emitted
    logic clear_all;  // end of merge: clear every flag
  } ctrl_t;

  // Flags carried by the search token along the chain.
  typedef struct packed {
    logic ready;       // every active open list holds a head
    logic found;       // at least one active head seen
    logic two;         // at least two active heads seen
    logic all_closed;  // every active list is closed
    logic best_closed; // list holding the current minimum is closed
  } flags_t;

endpackage

FILE: rtl/kwm_if.sv
// Channel interfaces of the k-way merge: input items, results and configuration.
interface kwm_in_if #(
  parameter int LIST_W  = 3,
  parameter int VALUE_W = 16
);
  logic                      valid;
  logic                      ready;
  logic [LIST_W-1:0]         list_index;
  logic                      has_value;
  logic signed [VALUE_W-1:0] sample_value;
  logic                      list_end;

  modport source (output valid, list_index, has_value, sample_value, list_end,
                  input ready);
  modport sink (input valid, list_index, has_value, sample_value, list_end,
                output ready);
endinterface

interface kwm_out_if #(
  parameter int LIST_W  = 3,
  parameter int VALUE_W = 16
);
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic signed [VALUE_W-1:0] merged_value;
  logic [LIST_W-1:0]         source_list;
  logic                      run_last;

  modport source (output valid, kind, merged_value, source_list, run_last,
                  input ready);
  modport sink (input valid, kind, merged_value, source_list, run_last,
                output ready);
endinterface

interface kwm_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [kwm_pkg::CFG_W-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: rtl/kwm_cell.sv
// One list slot of the merge chain: head storage, flags and one search step.
module kwm_cell #(
  parameter int NUM_LISTS   = kwm_pkg::NUM_LISTS_DEF,
  parameter int VALUE_WIDTH = kwm_pkg::VALUE_WIDTH_DEF,
  parameter int IDX         = 0,
  localparam int LIST_W     = $clog2(NUM_LISTS),
  localparam int LC_W       = $clog2(NUM_LISTS + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  kwm_pkg::ctrl_t                ctrl,
  input  logic [LIST_W-1:0]             sel_idx,
  input  logic signed [VALUE_WIDTH-1:0] load_value,
  input  logic [LC_W-1:0]               k_eff,
  input  kwm_pkg::flags_t               tok_f_in,
  input  logic signed [VALUE_WIDTH-1:0] tok_v_in,
  input  logic [LIST_W-1:0]             tok_i_in,
  output kwm_pkg::flags_t               tok_f_out,
  output logic signed [VALUE_WIDTH-1:0] tok_v_out,
  output logic [LIST_W-1:0]             tok_i_out
);

  logic                          present_r, present_nxt;
  logic                          closed_r, closed_nxt;
  logic signed [VALUE_WIDTH-1:0] head_r;
  kwm_pkg::flags_t               tok_f_r, tok_f_nxt;
  logic signed [VALUE_WIDTH-1:0] tok_v_r, tok_v_nxt;
  logic [LIST_W-1:0]             tok_i_r, tok_i_nxt;
  logic                          active;
  logic                          hit;
  logic                          load_ok;

  assign active  = LC_W'(IDX) < k_eff;
  assign hit     = sel_idx == LIST_W'(IDX);
  assign load_ok = ctrl.load && hit && active && !present_r && !closed_r;

  // Flag updates: the end marker clears all, an emission frees the slot, a load sets them.
  always_comb begin
    present_nxt = present_r;
    closed_nxt  = closed_r;
    if (ctrl.clear_all) begin
      present_nxt = 1'b0;
      closed_nxt  = 1'b0;
    end else if (ctrl.pop && hit) begin
      present_nxt = 1'b0;
    end else if (load_ok) begin
      if (ctrl.has_value) present_nxt = 1'b1;
      if (ctrl.list_end) closed_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= 1'b0;
      closed_r  <= 1'b0;
    end else begin
      present_r <= present_nxt;
      closed_r  <= closed_nxt;
    end
  end

  // Head value needs no reset; it is only read while present.
  always_ff @(posedge clk) begin
    if (load_ok && ctrl.has_value) begin
      head_r <= load_value;
    end
  end

  // Search step: fold this slot into the token passing along the chain.
  // A strictly smaller value wins, so ties stay with the lower index.
  always_comb begin
    tok_f_nxt = tok_f_in;
    tok_v_nxt = tok_v_in;
    tok_i_nxt = tok_i_in;
    if (active) begin
      tok_f_nxt.ready      = tok_f_in.ready && (closed_r || present_r);
      tok_f_nxt.all_closed = tok_f_in.all_closed && closed_r;
      if (present_r) begin
        tok_f_nxt.found = 1'b1;
        tok_f_nxt.two   = tok_f_in.two || tok_f_in.found;
        if (!tok_f_in.found || (head_r < tok_v_in)) begin
          tok_v_nxt             = head_r;
          tok_i_nxt             = LIST_W'(IDX);
          tok_f_nxt.best_closed = closed_r;
        end
      end
    end
  end

  // Token register towards the next cell.
  always_ff @(posedge clk) begin
    tok_f_r <= tok_f_nxt;
    tok_v_r <= tok_v_nxt;
    tok_i_r <= tok_i_nxt;
  end

  assign tok_f_out = tok_f_r;
  assign tok_v_out = tok_v_r;
  assign tok_i_out = tok_i_r;

endmodule

FILE: rtl/k_way_sorted_merge_top.sv
// Top level of the k-way sorted merge: cell chain, sequencer, output register.
//
//  Channel  | Direction | Payload
//  ---------+-----------+----------------------------------------------------
//  in_ch    | sink      | list_index, has_value, sample_value, list_end
//  out_ch   | source    | kind, merged_value, source_list, run_last
//  cfg_ch   | sink      | data = active_lists (always ready)
//
// Each search passes a token through the NUM_LISTS cells, one per cycle, and
// then a decision step acts on the token that leaves the last cell. An item
// runs one search per result; an item that emits nothing still needs one
// search.
// Reset is synchronous and clears all flags; head values are not cleared.
// A stalled output holds the decision step; a new transaction is taken only
// once the previous item's searches are finished.
`include "k_way_sorted_merge_top_defines.svh"

module k_way_sorted_merge_top #(
  parameter int NUM_LISTS   = kwm_pkg::NUM_LISTS_DEF,
  parameter int VALUE_WIDTH = kwm_pkg::VALUE_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  kwm_in_if.sink     in_ch,
  kwm_out_if.source  out_ch,
  kwm_cfg_if.sink    cfg_ch
);

  localparam int LIST_W = $clog2(NUM_LISTS);
  localparam int LC_W   = $clog2(NUM_LISTS + 1);
  localparam int CNT_W  = $clog2(NUM_LISTS);

  kwm_pkg::state_t               state_r, state_nxt;
  logic [CNT_W-1:0]              sweep_cnt_r, sweep_cnt_nxt;
  logic [kwm_pkg::CFG_W-1:0]     active_lists_r;
  logic [LC_W-1:0]               k_eff;
  kwm_pkg::ctrl_t                ctrl;
  logic [LIST_W-1:0]             sel_idx;

  kwm_pkg::flags_t               tok_f [0:NUM_LISTS];
  logic signed [VALUE_WIDTH-1:0] tok_v [0:NUM_LISTS];
  logic [LIST_W-1:0]             tok_i [0:NUM_LISTS];

  logic                          out_valid_r;
  logic                          out_kind_r;
  logic signed [VALUE_WIDTH-1:0] out_value_r;
  logic [LIST_W-1:0]             out_src_r;
  logic                          out_last_r;

  logic                          emit_val;
  logic                          emit_end;
  logic                          out_free;
  logic                          out_load;
  logic                          load_last;

  // Configuration register, written whenever its channel offers data.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_lists_r <= kwm_pkg::ACTIVE_RESET;
    end else if (cfg_ch.valid) begin
      active_lists_r <= cfg_ch.data;
    end
  end

  // Effective list count: zero acts as one, large values saturate.
  always_comb begin
    if (active_lists_r == '0) begin
      k_eff = LC_W'(1);
    end else if (32'(active_lists_r) > NUM_LISTS) begin
      k_eff = LC_W'(NUM_LISTS);
    end else begin
      k_eff = LC_W'(active_lists_r);
    end
  end

  // Fresh search token entering the first cell.
  assign tok_f[0] = '{ready: 1'b1, found: 1'b0, two: 1'b0, all_closed: 1'b1,
                      best_closed: 1'b0};
  assign tok_v[0] = '0;
  assign tok_i[0] = '0;

  // The chain of list cells.
  for (genvar g = 0; g < NUM_LISTS; g++) begin : g_cell
    kwm_cell #(
      .NUM_LISTS  (NUM_LISTS),
      .VALUE_WIDTH(VALUE_WIDTH),
      .IDX        (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .sel_idx   (sel_idx),
      .load_value(in_ch.sample_value),
      .k_eff     (k_eff),
      .tok_f_in  (tok_f[g]),
      .tok_v_in  (tok_v[g]),
      .tok_i_in  (tok_i[g]),
      .tok_f_out (tok_f[g+1]),
      .tok_v_out (tok_v[g+1]),
      .tok_i_out (tok_i[g+1])
    );
  end

  // Decision on the token that has left the last cell.
  assign emit_val = tok_f[NUM_LISTS].ready && tok_f[NUM_LISTS].found;
  assign emit_end = tok_f[NUM_LISTS].all_closed && !tok_f[NUM_LISTS].found;
  assign out_free = !out_valid_r || out_ch.ready;

  // After popping an open list the cascade stops; after a closed one it goes
  // on if another head waits or the end marker follows.
  assign load_last = !tok_f[NUM_LISTS].best_closed ||
                     (!tok_f[NUM_LISTS].two && !tok_f[NUM_LISTS].all_closed);

  // Sequencer: next state and cell commands.
  always_comb begin
    state_nxt      = state_r;
    sweep_cnt_nxt  = sweep_cnt_r;
    ctrl           = '0;
    ctrl.has_value = in_ch.has_value;
    ctrl.list_end  = in_ch.list_end;
    sel_idx        = in_ch.list_index;
    in_ch.ready    = 1'b0;
    out_load       = 1'b0;
    unique case (state_r)
      kwm_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          ctrl.load     = 1'b1;
          sweep_cnt_nxt = '0;
          state_nxt     = kwm_pkg::ST_SWEEP;
        end
      end
      kwm_pkg::ST_SWEEP: begin
        if (sweep_cnt_r == CNT_W'(NUM_LISTS - 1)) begin
          state_nxt = kwm_pkg::ST_DECIDE;
        end else begin
          sweep_cnt_nxt = sweep_cnt_r + 1'b1;
        end
      end
      kwm_pkg::ST_DECIDE: begin
        sel_idx = tok_i[NUM_LISTS];
        if (!emit_val && !emit_end) begin
          state_nxt = kwm_pkg::ST_IDLE;
        end else if (out_free) begin
          out_load = 1'b1;
          if (emit_val) begin
            ctrl.pop      = 1'b1;
            sweep_cnt_nxt = '0;
            state_nxt     = load_last ? kwm_pkg::ST_IDLE : kwm_pkg::ST_SWEEP;
          end else begin
            ctrl.clear_all = 1'b1;
            state_nxt      = kwm_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = kwm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kwm_pkg::ST_IDLE;
      sweep_cnt_r <= '0;
    end else begin
      state_r     <= state_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
    end
  end

  // Output register: valid flag under reset, payload loaded on a decision.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (emit_val) begin
        out_kind_r  <= kwm_pkg::KIND_VALUE;
        out_value_r <= tok_v[NUM_LISTS];
        out_src_r   <= tok_i[NUM_LISTS];
        out_last_r  <= load_last;
      end else begin
        out_kind_r  <= kwm_pkg::KIND_END;
        out_value_r <= '0;
        out_src_r   <= '0;
        out_last_r  <= 1'b1;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_kind_r;
  assign out_ch.merged_value = out_value_r;
  assign out_ch.source_list  = out_src_r;
  assign out_ch.run_last     = out_last_r;

  // Checks on the sequencer and the output register.
  `KWM_ASSERT_NOW(a_load_into_free, clk, rst_n, out_load,
                  !out_valid_r || out_ch.ready, "output register overwritten while stalled")
  `KWM_ASSERT_NOW(a_end_is_last, clk, rst_n, out_valid_r && out_kind_r == kwm_pkg::KIND_END,
                  out_last_r, "end marker without run_last")
  `KWM_ASSERT_NEXT(a_end_to_idle, clk, rst_n, out_load && emit_end,
                   state_r == kwm_pkg::ST_IDLE, "end marker did not finish the item")
  `KWM_ASSERT_NOW(a_cnt_bound, clk, rst_n, state_r == kwm_pkg::ST_SWEEP,
                  sweep_cnt_r <= CNT_W'(NUM_LISTS - 1), "sweep counter out of range")

endmodule
